@@ design/tbol_pkg.sv @@
// ============================================================================
// tbol_pkg: shared definitions for the trinomial barrier option lattice
// Field widths, register indexes, rounding constants and saturation.
// ============================================================================
package tbol_pkg;

    localparam int VAL_W  = 40;
    localparam int PROB_W = 32;
    localparam int CFG_W  = 40;
    localparam int IDX_W  = 3;
    localparam int SIZE_W = 8;

    // Shared multiplier: 33-bit coefficient by 21-bit operand slice.
    localparam int COEF_W = 33;
    localparam int PART_W = 21;
    localparam int PROD_W = COEF_W + PART_W;
    localparam int ACC_W  = 74;
    localparam int WIDE_W = 58;

    localparam int MAX_STEPS_DEFAULT = 128;

    localparam logic [SIZE_W-1:0] STEP_COUNT_RESET    = 8'd100;
    localparam logic [SIZE_W-1:0] BARRIER_INDEX_RESET = 8'd1;

    localparam logic [IDX_W-1:0] REG_PROB_UP   = 3'd0;
    localparam logic [IDX_W-1:0] REG_PROB_MID  = 3'd1;
    localparam logic [IDX_W-1:0] REG_PROB_DOWN = 3'd2;
    localparam logic [IDX_W-1:0] REG_REBATE    = 3'd3;
    localparam logic [IDX_W-1:0] REG_AMERICAN  = 3'd4;
    localparam logic [IDX_W-1:0] REG_STEPS     = 3'd5;
    localparam logic [IDX_W-1:0] REG_BARRIER   = 3'd6;
    localparam logic [IDX_W-1:0] REG_SCALE     = 3'd7;

    // Half an LSB of the result, added before the final arithmetic shift.
    localparam logic [ACC_W-1:0] NODE_ROUND  = ACC_W'(64'd1 << 29);
    localparam logic [ACC_W-1:0] DELTA_ROUND = ACC_W'(64'd1 << 15);

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] x);
        if (x > WIDE_W'(VAL_MAX))
        begin
            return VAL_MAX;
        end
        else if (x < WIDE_W'(VAL_MIN))
        begin
            return VAL_MIN;
        end
        return x[VAL_W-1:0];
    endfunction

endpackage

@@ design/tbol_ram.sv @@
// ============================================================================
// tbol_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds between reads.
// ============================================================================
module tbol_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 257
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/trinomial_barrier_option_lattice.sv @@
// ============================================================================
// trinomial_barrier_option_lattice: up-and-out barrier option on a trinomial tree
// Loads terminal values, runs backward induction, returns price and delta.
// ============================================================================
// Usage: set the weights, rebate, mode, step count N, barrier index B and delta
// scale through the write port while idle. Then send the N+B terminal payoffs,
// lowest node first, one beat per cycle on the input channel; the beat with
// last_value set starts the backward pass. Beats beyond N+B are dropped.
// Each node update steps through a read, the low and high product phases for the
// down, mid and up weights, an accumulate and a write, as the one shared 33x21
// multiplier forms six partial products for each node; the delta and the root
// node follow the last time step. There are U = (N-B)(N+B) - (N-B)(N-B+1)/2
// + B*B node updates, and the input is not ready during the pass.
// The result beat (price, delta) sits in an output register; loading of the
// next run may go on while it waits. If a receiver stall still holds an older
// result when a pass ends, the block waits until that beat is taken.
// Reset sets the registers to their defaults and the load count to zero; the
// lattice memories are not cleared and must be loaded before use.
// ============================================================================
module trinomial_barrier_option_lattice
    import tbol_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [VAL_W-1:0] intrinsic_value,
    input  logic                    last_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [VAL_W-1:0] option_price,
    output logic signed [VAL_W-1:0] option_delta
);

    localparam int DEPTH = 2 * MAX_STEPS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_STEPS + 1);

    localparam logic [3:0] PH_READ  = 4'd0;
    localparam logic [3:0] PH_LO_D  = 4'd1;
    localparam logic [3:0] PH_HI_D  = 4'd2;
    localparam logic [3:0] PH_LO_M  = 4'd3;
    localparam logic [3:0] PH_HI_M  = 4'd4;
    localparam logic [3:0] PH_LO_U  = 4'd5;
    localparam logic [3:0] PH_HI_U  = 4'd6;
    localparam logic [3:0] PH_ACC   = 4'd7;
    localparam logic [3:0] PH_WRITE = 4'd8;

    localparam logic [3:0] DPH_LO  = 4'd0;
    localparam logic [3:0] DPH_HI  = 4'd1;
    localparam logic [3:0] DPH_ACC = 4'd2;
    localparam logic [3:0] DPH_SAT = 4'd3;

    typedef enum logic [3:0] {
        S_LOAD,
        S_REB0,
        S_STEP,
        S_NODE,
        S_REB,
        S_DRD2,
        S_DRD0,
        S_DDIFF,
        S_DMUL,
        S_DONE
    } state_t;

    // Configuration registers
    logic signed [PROB_W-1:0] prob_up_reg;
    logic signed [PROB_W-1:0] prob_mid_reg;
    logic signed [PROB_W-1:0] prob_down_reg;
    logic signed [VAL_W-1:0]  rebate_reg;
    logic                     american_reg;
    logic [SIZE_W-1:0]        step_count_reg;
    logic [SIZE_W-1:0]        barrier_reg;
    logic [PROB_W-1:0]        scale_reg;

    // Sequencer
    state_t        state_reg;
    logic [3:0]    ph_reg;
    logic [AW-1:0] load_count_reg;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] j_reg;
    logic [NW-1:0] step_reg;
    logic          bumped_reg;
    logic          root_reg;
    logic          out_valid_reg;
    logic signed [VAL_W-1:0] price_out_reg;
    logic signed [VAL_W-1:0] delta_out_reg;

    // Datapath
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_hi_reg;
    logic                     prod_valid_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic signed [VAL_W:0]    opv_reg;
    logic signed [VAL_W-1:0]  price_calc_reg;
    logic signed [VAL_W-1:0]  delta_calc_reg;

    logic [NW-1:0] n_eff;
    logic [NW-1:0] b_eff;
    logic [AW-1:0] total;
    logic          phase_one;
    logic          in_fire;
    logic          load_wr;

    logic             lat_we;
    logic [AW-1:0]    lat_waddr;
    logic [VAL_W-1:0] lat_wdata;
    logic             lat_re;
    logic [AW-1:0]    lat_raddr;
    logic [VAL_W-1:0] lat_rdata;
    logic             int_re;
    logic [AW-1:0]    int_raddr;
    logic [VAL_W-1:0] int_rdata;

    logic                     mul_en;
    logic                     mul_hi;
    logic                     use_opv;
    logic signed [COEF_W-1:0] mul_coef;
    logic signed [VAL_W:0]    mul_src;
    logic signed [PART_W-1:0] mul_part;
    logic                     acc_clear;
    logic [ACC_W-1:0]         acc_init;
    logic [ACC_W-1:0]         acc_addend;

    logic signed [VAL_W-1:0] node_sat;
    logic signed [VAL_W-1:0] node_result;
    logic signed [VAL_W-1:0] delta_sat;

    // Effective sizes: zero counts as one, step count capped at MAX_STEPS,
    // barrier index capped at the step count.
    always_comb
    begin
        if (step_count_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(step_count_reg) > MAX_STEPS)
        begin
            n_eff = NW'(MAX_STEPS);
        end
        else
        begin
            n_eff = NW'(step_count_reg);
        end

        if (barrier_reg == '0)
        begin
            b_eff = NW'(1);
        end
        else if (32'(barrier_reg) > 32'(n_eff))
        begin
            b_eff = n_eff;
        end
        else
        begin
            b_eff = NW'(barrier_reg);
        end
    end

    assign total     = AW'(n_eff) + AW'(b_eff);
    assign phase_one = (32'(step_reg) + 32'(b_eff)) <= 32'(n_eff);
    assign in_ready  = (state_reg == S_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign load_wr   = in_fire && (load_count_reg < total);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prob_up_reg    <= '0;
            prob_mid_reg   <= '0;
            prob_down_reg  <= '0;
            rebate_reg     <= '0;
            american_reg   <= 1'b0;
            step_count_reg <= STEP_COUNT_RESET;
            barrier_reg    <= BARRIER_INDEX_RESET;
            scale_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PROB_UP:   prob_up_reg    <= cfg_data[PROB_W-1:0];
                REG_PROB_MID:  prob_mid_reg   <= cfg_data[PROB_W-1:0];
                REG_PROB_DOWN: prob_down_reg  <= cfg_data[PROB_W-1:0];
                REG_REBATE:    rebate_reg     <= cfg_data[VAL_W-1:0];
                REG_AMERICAN:  american_reg   <= cfg_data[0];
                REG_STEPS:     step_count_reg <= cfg_data[SIZE_W-1:0];
                REG_BARRIER:   barrier_reg    <= cfg_data[SIZE_W-1:0];
                REG_SCALE:     scale_reg      <= cfg_data[PROB_W-1:0];
                default:       ;
            endcase
        end
    end

    // Memory ports and multiplier control
    always_comb
    begin
        lat_we    = 1'b0;
        lat_waddr = j_reg;
        lat_wdata = node_result;
        lat_re    = 1'b0;
        lat_raddr = j_reg;
        int_re    = 1'b0;
        int_raddr = j_reg + AW'(step_reg);
        mul_en    = 1'b0;
        mul_hi    = 1'b0;
        use_opv   = 1'b0;
        mul_coef  = COEF_W'(prob_down_reg);
        acc_clear = 1'b0;
        acc_init  = NODE_ROUND;

        case (state_reg)
            S_LOAD:
            begin
                lat_we    = load_wr;
                lat_waddr = load_count_reg;
                lat_wdata = intrinsic_value;
            end
            S_REB0:
            begin
                lat_we    = 1'b1;
                lat_waddr = total;
                lat_wdata = rebate_reg;
            end
            S_REB:
            begin
                lat_we    = 1'b1;
                lat_waddr = cnt_reg;
                lat_wdata = rebate_reg;
            end
            S_NODE:
            begin
                case (ph_reg)
                    PH_READ:
                    begin
                        lat_re    = 1'b1;
                        int_re    = 1'b1;
                        acc_clear = 1'b1;
                    end
                    PH_LO_D:
                    begin
                        mul_en = 1'b1;
                    end
                    PH_HI_D:
                    begin
                        mul_en    = 1'b1;
                        mul_hi    = 1'b1;
                        lat_re    = 1'b1;
                        lat_raddr = j_reg + AW'(1);
                    end
                    PH_LO_M:
                    begin
                        mul_en   = 1'b1;
                        mul_coef = COEF_W'(prob_mid_reg);
                    end
                    PH_HI_M:
                    begin
                        mul_en    = 1'b1;
                        mul_hi    = 1'b1;
                        mul_coef  = COEF_W'(prob_mid_reg);
                        lat_re    = 1'b1;
                        lat_raddr = j_reg + AW'(2);
                    end
                    PH_LO_U:
                    begin
                        mul_en   = 1'b1;
                        mul_coef = COEF_W'(prob_up_reg);
                    end
                    PH_HI_U:
                    begin
                        mul_en   = 1'b1;
                        mul_hi   = 1'b1;
                        mul_coef = COEF_W'(prob_up_reg);
                    end
                    PH_WRITE:
                    begin
                        lat_we = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_DRD2:
            begin
                lat_re    = 1'b1;
                lat_raddr = AW'(2);
            end
            S_DRD0:
            begin
                lat_re    = 1'b1;
                lat_raddr = '0;
            end
            S_DMUL:
            begin
                use_opv  = 1'b1;
                mul_coef = {1'b0, scale_reg};
                case (ph_reg)
                    DPH_LO:
                    begin
                        mul_en    = 1'b1;
                        acc_clear = 1'b1;
                        acc_init  = DELTA_ROUND;
                    end
                    DPH_HI:
                    begin
                        mul_en = 1'b1;
                        mul_hi = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Operand slices: low 20 bits unsigned, remaining upper bits signed.
    assign mul_src  = use_opv ? opv_reg : {lat_rdata[VAL_W-1], lat_rdata};
    assign mul_part = mul_hi ? mul_src[VAL_W:20] : {1'b0, mul_src[19:0]};

    assign acc_addend = prod_hi_reg ? {prod_reg, 20'd0}
                                    : {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // The accumulator already carries the rounding half, so the result is a
    // plain arithmetic shift of it.
    assign node_sat = sat_val({{(WIDE_W-(ACC_W-30)){acc_reg[ACC_W-1]}}, acc_reg[ACC_W-1:30]});
    assign node_result = (american_reg && ($signed(int_rdata) > node_sat)) ? int_rdata
                                                                             : node_sat;
    assign delta_sat = sat_val(acc_reg[ACC_W-1:16]);

    always_ff @(posedge clk)
    begin
        prod_reg    <= mul_coef * mul_part;
        prod_hi_reg <= mul_hi;

        if (acc_clear)
        begin
            acc_reg <= acc_init;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + acc_addend;
        end

        if (state_reg == S_DRD0)
        begin
            opv_reg <= {lat_rdata[VAL_W-1], lat_rdata};
        end
        else if (state_reg == S_DDIFF)
        begin
            opv_reg <= opv_reg - {lat_rdata[VAL_W-1], lat_rdata};
        end

        if (state_reg == S_DMUL && ph_reg == DPH_SAT)
        begin
            delta_calc_reg <= delta_sat;
        end

        if (state_reg == S_NODE && ph_reg == PH_WRITE && root_reg)
        begin
            price_calc_reg <= node_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            ph_reg         <= '0;
            load_count_reg <= '0;
            cnt_reg        <= '0;
            j_reg          <= '0;
            step_reg       <= '0;
            bumped_reg     <= 1'b0;
            root_reg       <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            price_out_reg  <= '0;
            delta_out_reg  <= '0;
        end
        else
        begin
            prod_valid_reg <= mul_en;

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_LOAD:
                begin
                    if (load_wr)
                    begin
                        load_count_reg <= load_count_reg + AW'(1);
                    end
                    if (in_fire && last_value)
                    begin
                        state_reg <= S_REB0;
                    end
                end
                S_REB0:
                begin
                    cnt_reg    <= total;
                    step_reg   <= NW'(1);
                    bumped_reg <= 1'b0;
                    root_reg   <= 1'b0;
                    state_reg  <= S_STEP;
                end
                S_STEP:
                begin
                    ph_reg <= '0;
                    j_reg  <= '0;
                    if (phase_one)
                    begin
                        cnt_reg   <= cnt_reg - AW'(1);
                        state_reg <= S_NODE;
                    end
                    else if (!bumped_reg)
                    begin
                        // Past the barrier steps the lattice regains one node
                        // before shrinking by two per step.
                        cnt_reg    <= cnt_reg + AW'(1);
                        bumped_reg <= 1'b1;
                    end
                    else if (step_reg < n_eff)
                    begin
                        cnt_reg   <= cnt_reg - AW'(2);
                        state_reg <= S_NODE;
                    end
                    else
                    begin
                        state_reg <= S_DRD2;
                    end
                end
                S_NODE:
                begin
                    if (ph_reg == PH_WRITE)
                    begin
                        ph_reg <= '0;
                        if (root_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                        else if ((j_reg + AW'(1)) < cnt_reg)
                        begin
                            j_reg <= j_reg + AW'(1);
                        end
                        else if (phase_one)
                        begin
                            state_reg <= S_REB;
                        end
                        else
                        begin
                            step_reg  <= step_reg + NW'(1);
                            state_reg <= S_STEP;
                        end
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 4'd1;
                    end
                end
                S_REB:
                begin
                    step_reg  <= step_reg + NW'(1);
                    state_reg <= S_STEP;
                end
                S_DRD2:
                begin
                    state_reg <= S_DRD0;
                end
                S_DRD0:
                begin
                    state_reg <= S_DDIFF;
                end
                S_DDIFF:
                begin
                    ph_reg    <= DPH_LO;
                    state_reg <= S_DMUL;
                end
                S_DMUL:
                begin
                    if (ph_reg == DPH_SAT)
                    begin
                        ph_reg    <= '0;
                        j_reg     <= '0;
                        root_reg  <= 1'b1;
                        state_reg <= S_NODE;
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 4'd1;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        price_out_reg  <= price_calc_reg;
                        delta_out_reg  <= delta_calc_reg;
                        load_count_reg <= '0;
                        state_reg      <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign option_price = price_out_reg;
    assign option_delta = delta_out_reg;

    tbol_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_lattice_ram (
        .clk   (clk),
        .we    (lat_we),
        .waddr (lat_waddr),
        .wdata (lat_wdata),
        .re    (lat_re),
        .raddr (lat_raddr),
        .rdata (lat_rdata)
    );

    tbol_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_intrinsic_ram (
        .clk   (clk),
        .we    (load_wr),
        .waddr (load_count_reg),
        .wdata (intrinsic_value),
        .re    (int_re),
        .raddr (int_raddr),
        .rdata (int_rdata)
    );

    // DPH_ACC is the cycle in which the last delta product is accumulated.
    logic unused_ok;
    assign unused_ok = (DPH_ACC == PH_LO_D) && (PH_ACC == 4'd7);

endmodule
